@@ rtl/uwcs_pkg.sv @@
package uwcs_pkg;

    localparam int TICKS_PER_SECOND  = 100;
    localparam int FULL_DERATE_COUNT = 7;
    localparam int DERATE_W          = $clog2(FULL_DERATE_COUNT + 1);

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam logic [6:0]  POWER_FLOOR    = 7'd50;
    localparam logic [6:0]  POWER_SAT_SPAN = 7'd51;
    localparam logic [6:0]  AMP_MAX        = 7'd127;
    localparam logic [7:0]  AMP_SCALE      = 8'd255;
    localparam logic [13:0] RECIP_100      = 14'd10486;
    localparam int          RECIP_SHIFT    = 20;
    localparam int          DERATE_STEP    = 10;
    localparam logic [15:0] COUNT_SAT      = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_READY = 3'd0,
        PH_DOWN  = 3'd1,
        PH_WELD  = 3'd2,
        PH_HOLD  = 3'd3,
        PH_UP    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        REG_TRIGGER_MODE     = 3'd0,
        REG_EXIT_MODE        = 3'd1,
        REG_TRAVEL_TICKS     = 3'd2,
        REG_WELD_TICKS       = 3'd3,
        REG_HOLD_TICKS       = 3'd4,
        REG_POWER_PERCENT    = 3'd5,
        REG_ENERGY_TARGET    = 3'd6,
        REG_BACKSTOP_SECONDS = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        trigger_mode;
        logic [1:0]  exit_mode;
        logic [15:0] travel_ticks;
        logic [15:0] weld_ticks;
        logic [15:0] hold_ticks;
        logic [6:0]  power_percent;
        logic [15:0] energy_target;
        logic [3:0]  backstop_seconds;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        trigger_mode:     1'b0,
        exit_mode:        2'd0,
        travel_ticks:     16'd0,
        weld_ticks:       16'd0,
        hold_ticks:       16'd0,
        power_percent:    POWER_FLOOR,
        energy_target:    16'd0,
        backstop_seconds: 4'd0
    };

    typedef struct packed {
        logic        start_req;
        logic        abort;
        logic        down_edge;
        logic        up_edge;
        logic [15:0] energy_now;
        logic [6:0]  stage1_power;
        logic [6:0]  stage2_power;
        logic [15:0] stage_switch_ticks;
        logic [15:0] stage_end_ticks;
    } item_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       solenoid_down;
        logic [6:0] amplitude;
        logic       sonic_on;
        logic       amp_step;
        logic       sonic_off;
        logic       energy_fault;
        logic       part_done;
    } result_t;

    // amplitude = (p - 50) * 255 / 100, divide by 100 via reciprocal
    function automatic logic [6:0] power_to_amp(input logic [6:0] p);
        logic [6:0]  d;
        logic [13:0] prod;
        logic [27:0] scaled;
        d      = p - POWER_FLOOR;
        prod   = 14'(d) * 14'(AMP_SCALE);
        scaled = 28'(prod) * 28'(RECIP_100);
        if (p < POWER_FLOOR)
            return '0;
        else if (d >= POWER_SAT_SPAN)
            return AMP_MAX;
        else
            return 7'(scaled >> RECIP_SHIFT);
    endfunction

    function automatic logic [6:0] derated_amp(input logic [6:0] p,
                                               input logic [DERATE_W-1:0] comp);
        logic [6:0] a;
        logic [7:0] red;
        a   = power_to_amp(p);
        red = 8'((FULL_DERATE_COUNT - int'(comp)) * DERATE_STEP);
        if (int'(comp) < FULL_DERATE_COUNT)
            return (8'(a) >= red) ? 7'(8'(a) - red) : '0;
        else
            return a;
    endfunction

endpackage

@@ rtl/uwcs_ifs.sv @@
interface uwcs_item_if;
    import uwcs_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface uwcs_result_if;
    import uwcs_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/uwcs_cfg.sv @@
module uwcs_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uwcs_pkg::CFG_AW-1:0] paddr,
    input  logic [uwcs_pkg::CFG_DW-1:0] pwdata,
    output logic [uwcs_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output uwcs_pkg::cfg_t              cfg
);
    import uwcs_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_TRIGGER_MODE:     cfg_next.trigger_mode     = pwdata[0];
                REG_EXIT_MODE:        cfg_next.exit_mode        = pwdata[1:0];
                REG_TRAVEL_TICKS:     cfg_next.travel_ticks     = pwdata[15:0];
                REG_WELD_TICKS:       cfg_next.weld_ticks       = pwdata[15:0];
                REG_HOLD_TICKS:       cfg_next.hold_ticks       = pwdata[15:0];
                REG_POWER_PERCENT:    cfg_next.power_percent    = pwdata[6:0];
                REG_ENERGY_TARGET:    cfg_next.energy_target    = pwdata[15:0];
                REG_BACKSTOP_SECONDS: cfg_next.backstop_seconds = pwdata[3:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TRIGGER_MODE:     prdata = CFG_DW'(cfg_reg.trigger_mode);
            REG_EXIT_MODE:        prdata = CFG_DW'(cfg_reg.exit_mode);
            REG_TRAVEL_TICKS:     prdata = CFG_DW'(cfg_reg.travel_ticks);
            REG_WELD_TICKS:       prdata = CFG_DW'(cfg_reg.weld_ticks);
            REG_HOLD_TICKS:       prdata = CFG_DW'(cfg_reg.hold_ticks);
            REG_POWER_PERCENT:    prdata = CFG_DW'(cfg_reg.power_percent);
            REG_ENERGY_TARGET:    prdata = CFG_DW'(cfg_reg.energy_target);
            REG_BACKSTOP_SECONDS: prdata = CFG_DW'(cfg_reg.backstop_seconds);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/uwcs_core.sv @@
module uwcs_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  uwcs_pkg::item_t   word,
    input  uwcs_pkg::cfg_t    cfg,
    output uwcs_pkg::result_t res
);
    import uwcs_pkg::*;

    phase_t              phase_reg,    phase_next;
    logic                entered_reg,  entered_next;
    logic [15:0]         count_reg,    count_next;
    logic [DERATE_W-1:0] derate_reg,   derate_next;
    logic                sol_reg,      sol_next;
    logic                second_reg,   second_next;
    logic [15:0]         elapsed_reg,  elapsed_next;
    logic                trig_reg,     trig_next;
    logic [1:0]          exit_reg,     exit_next;
    logic                dpend_reg,    dpend_next;
    logic                upend_reg,    upend_next;

    logic        do_weld;
    logic        do_hold;
    logic        long_weld;
    logic [3:0]  bs_sec;
    logic [15:0] backstop;

    assign long_weld = cfg.weld_ticks >= 16'(FULL_DERATE_COUNT);
    assign bs_sec    = (cfg.backstop_seconds != '0) ? cfg.backstop_seconds : 4'd1;
    assign backstop  = 16'(32'(bs_sec) * 32'(TICKS_PER_SECOND));

    always_comb
    begin
        phase_next   = phase_reg;
        entered_next = entered_reg;
        count_next   = count_reg;
        derate_next  = derate_reg;
        sol_next     = sol_reg;
        second_next  = second_reg;
        elapsed_next = elapsed_reg;
        trig_next    = trig_reg;
        exit_next    = exit_reg;
        dpend_next   = dpend_reg;
        upend_next   = upend_reg;
        do_weld      = 1'b0;
        do_hold      = 1'b0;
        res          = '0;

        if (word.abort && phase_reg != PH_READY)
        begin
            res.sonic_off = (phase_reg == PH_WELD);
            sol_next      = 1'b0;
            phase_next    = PH_READY;
            entered_next  = 1'b0;
            count_next    = '0;
            second_next   = 1'b0;
            elapsed_next  = '0;
            exit_next     = '0;
            trig_next     = 1'b0;
            dpend_next    = 1'b0;
            upend_next    = 1'b0;
        end
        else
        begin
            if (word.down_edge)
                dpend_next = 1'b1;
            if (word.up_edge)
                upend_next = 1'b1;
            if (count_reg != '0)
                count_next = count_reg - 16'd1;

            unique case (phase_reg)
                PH_READY:
                begin
                    if (word.start_req)
                    begin
                        phase_next   = PH_DOWN;
                        trig_next    = cfg.trigger_mode;
                        count_next   = cfg.travel_ticks;
                        entered_next = 1'b0;
                        dpend_next   = 1'b0;
                    end
                end
                PH_DOWN:
                begin
                    if (!entered_reg)
                    begin
                        entered_next = 1'b1;
                        sol_next     = 1'b1;
                    end
                    else if (trig_reg)
                    begin
                        if (dpend_next)
                        begin
                            dpend_next = 1'b0;
                            do_weld    = 1'b1;
                        end
                    end
                    else if (count_next == '0)
                    begin
                        do_weld = 1'b1;
                    end
                end
                PH_WELD:
                begin
                    if (!entered_reg)
                    begin
                        entered_next = 1'b1;
                        res.sonic_on = 1'b1;
                        if (exit_reg[1])
                        begin
                            second_next   = 1'b0;
                            elapsed_next  = 16'd1;
                            res.amplitude = power_to_amp(word.stage1_power);
                        end
                        else
                        begin
                            res.amplitude = derated_amp(cfg.power_percent, derate_reg);
                        end
                    end
                    else if (exit_reg[1])
                    begin
                        if (elapsed_reg != COUNT_SAT)
                            elapsed_next = elapsed_reg + 16'd1;
                        if (!second_reg && elapsed_next >= word.stage_switch_ticks)
                        begin
                            second_next   = 1'b1;
                            res.amplitude = power_to_amp(word.stage2_power);
                            res.amp_step  = 1'b1;
                        end
                        if (elapsed_next >= word.stage_end_ticks)
                        begin
                            res.sonic_off = 1'b1;
                            do_hold       = 1'b1;
                        end
                    end
                    else if (exit_reg[0])
                    begin
                        if (cfg.energy_target != '0 && word.energy_now >= cfg.energy_target)
                        begin
                            res.sonic_off = 1'b1;
                            do_hold       = 1'b1;
                        end
                        else if (count_next == '0)
                        begin
                            res.sonic_off    = 1'b1;
                            res.energy_fault = 1'b1;
                            sol_next         = 1'b0;
                            entered_next     = 1'b0;
                            phase_next       = PH_READY;
                            exit_next        = '0;
                        end
                    end
                    else if (count_next == '0)
                    begin
                        res.sonic_off = 1'b1;
                        do_hold       = 1'b1;
                    end
                end
                PH_HOLD:
                begin
                    if (!entered_reg)
                    begin
                        entered_next = 1'b1;
                    end
                    else if (count_next == '0)
                    begin
                        entered_next = 1'b0;
                        phase_next   = PH_UP;
                        count_next   = cfg.travel_ticks;
                        if (trig_reg)
                            upend_next = 1'b1;
                    end
                end
                PH_UP:
                begin
                    if (!entered_reg)
                    begin
                        entered_next = 1'b1;
                        sol_next     = 1'b0;
                    end
                    else if (trig_reg ? upend_next : (count_next == '0))
                    begin
                        if (trig_reg)
                            upend_next = 1'b0;
                        entered_next  = 1'b0;
                        phase_next    = PH_READY;
                        res.part_done = 1'b1;
                        exit_next     = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_READY;
                    sol_next   = 1'b0;
                    exit_next  = '0;
                end
            endcase

            if (do_weld)
            begin
                entered_next = 1'b0;
                phase_next   = PH_WELD;
                exit_next    = cfg.exit_mode;
                second_next  = 1'b0;
                elapsed_next = '0;
                derate_next  = long_weld ? DERATE_W'(FULL_DERATE_COUNT)
                                         : cfg.weld_ticks[DERATE_W-1:0];
                if (cfg.exit_mode[0])
                    count_next = backstop;
                else
                    count_next = long_weld ? cfg.weld_ticks : 16'(FULL_DERATE_COUNT);
            end

            if (do_hold)
            begin
                entered_next = 1'b0;
                phase_next   = PH_HOLD;
                count_next   = cfg.hold_ticks;
            end
        end

        res.phase         = phase_next;
        res.solenoid_down = sol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_READY;
            entered_reg <= 1'b0;
            count_reg   <= '0;
            derate_reg  <= DERATE_W'(FULL_DERATE_COUNT);
            sol_reg     <= 1'b0;
            second_reg  <= 1'b0;
            elapsed_reg <= '0;
            trig_reg    <= 1'b0;
            exit_reg    <= '0;
            dpend_reg   <= 1'b0;
            upend_reg   <= 1'b0;
        end
        else if (adv)
        begin
            phase_reg   <= phase_next;
            entered_reg <= entered_next;
            count_reg   <= count_next;
            derate_reg  <= derate_next;
            sol_reg     <= sol_next;
            second_reg  <= second_next;
            elapsed_reg <= elapsed_next;
            trig_reg    <= trig_next;
            exit_reg    <= exit_next;
            dpend_reg   <= dpend_next;
            upend_reg   <= upend_next;
        end
    end

    a_sol_off_ready: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_READY |-> !sol_reg)
        else $error("solenoid driven while ready");

    a_amp_qualified: assert property (@(posedge clk) disable iff (!rst_n)
        res.amplitude != '0 |-> (res.sonic_on || res.amp_step))
        else $error("amplitude without start or change");

    a_start_in_weld: assert property (@(posedge clk) disable iff (!rst_n)
        res.sonic_on |-> (phase_reg == PH_WELD && !entered_reg))
        else $error("weld start outside weld entry");

    a_done_to_ready: assert property (@(posedge clk) disable iff (!rst_n)
        adv && res.part_done |=> phase_reg == PH_READY && !exit_reg[0] && !exit_reg[1])
        else $error("cycle done did not return to ready");

    a_fault_stops: assert property (@(posedge clk) disable iff (!rst_n)
        res.energy_fault |-> (res.sonic_off && phase_reg == PH_WELD))
        else $error("fault without stop");

endmodule

@@ rtl/ultrasonic_weld_cycle_sequencer.sv @@
// channel  dir  word
// item     in   start_req, abort, down/up edges, energy_now, stage settings
// result   out  phase, solenoid_down, amplitude, weld/cycle pulses
// apb      in   8 registers at 4*i, write on psel & penable & pwrite
//
// Two stages: input register, then sequencer logic into the result register.
// Sustained rate is one word per cycle while result.ready holds; each word goes input register, then result register.
// A result waiting unread holds the input register; with both full, input stalls.
// rst_n is asynchronous: phase to ready, pipeline empty, registers to defaults.
module ultrasonic_weld_cycle_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    uwcs_item_if.sink                   item,
    uwcs_result_if.source               result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uwcs_pkg::CFG_AW-1:0] paddr,
    input  logic [uwcs_pkg::CFG_DW-1:0] pwdata,
    output logic [uwcs_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import uwcs_pkg::*;

    cfg_t    cfg;
    logic    in_valid_reg,  in_valid_next;
    item_t   in_word_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_word_reg;
    result_t step_res;
    logic    adv;

    uwcs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uwcs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .word  (in_word_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    assign adv          = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready   = !in_valid_reg || adv;
    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

    assign in_valid_next  = (item.valid && item.ready) || (in_valid_reg && !adv);
    assign out_valid_next = adv || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_word_reg <= item.data;
        if (adv)
            out_word_reg <= step_res;
    end

endmodule
